// ----- hdl/mics_pkg.sv -----
// Shared types and constants for the MIPS integer core step block.
// Used by the channel interfaces and the top level; depends on nothing.
package mics_pkg;

    // Major opcodes
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_COP1    = 6'd17;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_SW      = 6'd43;
    localparam logic [5:0] OP_LWC1    = 6'd49;
    localparam logic [5:0] OP_SWC1    = 6'd57;
    localparam logic [5:0] OP_IO_0    = 6'd60;
    localparam logic [5:0] OP_IO_1    = 6'd61;
    localparam logic [5:0] OP_IO_2    = 6'd62;
    localparam logic [5:0] OP_IO_3    = 6'd63;

    // Function codes under the special opcode
    localparam logic [5:0] FN_SLL = 6'd0;
    localparam logic [5:0] FN_SRL = 6'd2;
    localparam logic [5:0] FN_JR  = 6'd8;
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_SLT = 6'd42;

    // Result status codes
    localparam logic [1:0] ST_EXEC    = 2'd0;
    localparam logic [1:0] ST_SKIP    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Return address register written by jal
    localparam logic [4:0] REG_RA = 5'd31;

    localparam int PW_W = 17;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_MUL,
        MS_RED,
        MS_LOAD
    } t_mstate;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        next_pc;
        logic               halted;
        logic               reg_written;
        logic [4:0]         reg_index;
        logic signed [31:0] reg_value;
        logic               mem_written;
        logic [11:0]        mem_index;
        logic signed [31:0] mem_value;
    } t_result;

endpackage

// ----- hdl/mics_if.sv -----
// Valid/ready channel interfaces: instruction requests, results, configuration.
// Depends on mics_pkg for the program length width.
interface mics_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface mics_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [31:0]        next_pc;
    logic               halted;
    logic               reg_written;
    logic [4:0]         reg_index;
    logic signed [31:0] reg_value;
    logic               mem_written;
    logic [11:0]        mem_index;
    logic signed [31:0] mem_value;

    modport source (output valid, output status, output next_pc, output halted,
                    output reg_written, output reg_index, output reg_value,
                    output mem_written, output mem_index, output mem_value,
                    input ready);
    modport sink   (input valid, input status, input next_pc, input halted,
                    input reg_written, input reg_index, input reg_value,
                    input mem_written, input mem_index, input mem_value,
                    output ready);
endinterface

interface mics_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mics_pkg::PW_W-1:0]   program_words;

    modport source (output valid, output program_words, input ready);
    modport sink   (input valid, input program_words, output ready);
endinterface

// ----- hdl/mics_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package needed.
module mics_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/mips_integer_core_step.sv -----
// Top level of the MIPS integer core step block.
// Depends on mics_pkg, the channel interfaces in mics_if.sv and mics_ram.
//
// One instruction request, fetched by the user at the PC of the previous result,
// gives one result. The register file sits in two copies of a 32-entry RAM (one
// per source operand) read as the request is accepted, so an ALU, branch or jump
// instruction passes straight through execute and a new request is taken every
// cycle while the output is not stalled; its result is registered in the output
// register. Loads and stores leave execute for a memory sequencer: the word
// address (rs + imm) modulo DATA_WORDS is formed by a reciprocal multiply,
// registered, then a multiply-back and one corrective subtract. A store is
// written in that reduce step and a load adds a data-memory read step; no new
// request is taken until the sequencer finishes. The data memory is cleared by
// a sweep over all DATA_WORDS words after reset, during which requests are
// refused; configuration writes are taken at any time. A register result is
// forwarded to a request accepted in the same cycle as the write.
module mips_integer_core_step #(
    parameter int DATA_WORDS = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mics_instr_if.sink            i_instr,
    mics_cfg_if.sink              i_cfg,
    mics_result_if.source         o_result
);

    localparam int          DA_W   = $clog2(DATA_WORDS);
    localparam logic [31:0] DW32   = 32'(DATA_WORDS);
    localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / DATA_WORDS);

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    logic [31:0]                 r_pc;
    logic [mics_pkg::PW_W-1:0]   r_pw;
    logic [31:0]                 r_rvalid;
    logic                        r_clr;
    logic [DA_W-1:0]             r_clr_addr;

    // Execute stage
    logic                        r_v1;
    logic [31:0]                 r_ins;
    logic                        r_byp_a;
    logic                        r_byp_b;
    logic [31:0]                 r_byp_val;

    // Memory sequencer
    mics_pkg::t_mstate           r_mstate;
    mics_pkg::t_mstate           n_mstate;
    logic                        r_m_load;
    logic [31:0]                 r_m_sum;
    logic [31:0]                 r_m_b;
    logic [4:0]                  r_m_rt;
    logic [31:0]                 r_m_npc;
    logic                        r_m_halt;
    logic [63:0]                 r_prod;
    logic [DA_W-1:0]             r_m_addr;

    // Output register
    logic                        r_ov;
    mics_pkg::t_result           r_out;
    mics_pkg::t_result           n_out;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic            rf_we;
    logic [4:0]      rf_widx;
    logic [31:0]     rf_wval;
    logic [4:0]      rf_raddr_a;
    logic [4:0]      rf_raddr_b;
    logic [31:0]     rf_a_q;
    logic [31:0]     rf_b_q;

    logic            dm_we;
    logic [DA_W-1:0] dm_waddr;
    logic [31:0]     dm_wdata;
    logic [DA_W-1:0] dm_raddr;
    logic [31:0]     dm_q;

    mics_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_widx),
        .i_wdata (rf_wval),
        .i_raddr (rf_raddr_a),
        .o_rdata (rf_a_q)
    );

    mics_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_widx),
        .i_wdata (rf_wval),
        .i_raddr (rf_raddr_b),
        .o_rdata (rf_b_q)
    );

    mics_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_raddr (dm_raddr),
        .o_rdata (dm_q)
    );

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic out_free;
    logic in_acc;
    logic e_fire;
    logic e_to_seq;
    logic load_fire;
    logic store_fire;
    logic seq_fire;

    assign out_free     = !r_ov || o_result.ready;
    assign i_cfg.ready  = 1'b1;

    // Take a request when execute will be empty next cycle and no memory
    // operation is left over, and never during the clearing sweep.
    assign i_instr.ready = !r_clr &&
                           ((!r_v1 && r_mstate == mics_pkg::MS_IDLE) || e_fire || seq_fire);
    assign in_acc = i_instr.valid && i_instr.ready;

    // Read the operands of the incoming request; hold the address while execute stalls.
    assign rf_raddr_a = in_acc ? i_instr.instruction[25:21] : r_ins[25:21];
    assign rf_raddr_b = in_acc ? i_instr.instruction[20:16] : r_ins[20:16];

    // ------------------------------------------------------------------
    // Execute: decode, operand select with forwarding, ALU and next PC
    // ------------------------------------------------------------------
    logic [5:0]  e_op;
    logic [5:0]  e_fn;
    logic [4:0]  e_rs;
    logic [4:0]  e_rt;
    logic [4:0]  e_rd;
    logic [4:0]  e_sh;
    logic [15:0] e_imm;
    logic [31:0] e_simm;
    logic [31:0] e_a;
    logic [31:0] e_b;
    logic [31:0] e_pc4;
    logic [31:0] e_npc;
    logic [1:0]  e_status;
    logic        e_wr;
    logic        e_wr_en;
    logic [4:0]  e_widx;
    logic [31:0] e_wval;
    logic        e_mem;
    logic        e_load;
    logic        e_halt;
    logic [31:0] e_end;

    assign e_op   = r_ins[31:26];
    assign e_rs   = r_ins[25:21];
    assign e_rt   = r_ins[20:16];
    assign e_rd   = r_ins[15:11];
    assign e_sh   = r_ins[10:6];
    assign e_fn   = r_ins[5:0];
    assign e_imm  = r_ins[15:0];
    assign e_simm = {{16{e_imm[15]}}, e_imm};
    assign e_pc4  = r_pc + 32'd4;

    // Forward a write made in the cycle the request was accepted; unwritten
    // registers (and register zero) read as zero.
    assign e_a = r_byp_a ? r_byp_val : (r_rvalid[e_rs] ? rf_a_q : 32'd0);
    assign e_b = r_byp_b ? r_byp_val : (r_rvalid[e_rt] ? rf_b_q : 32'd0);

    always_comb begin
        e_npc    = e_pc4;
        e_status = mics_pkg::ST_EXEC;
        e_wr     = 1'b0;
        e_widx   = e_rt;
        e_wval   = 32'd0;
        e_mem    = 1'b0;
        e_load   = 1'b0;
        case (e_op)
            mics_pkg::OP_SPECIAL: begin
                e_widx = e_rd;
                case (e_fn)
                    mics_pkg::FN_ADD: begin
                        e_wr   = 1'b1;
                        e_wval = e_a + e_b;
                    end
                    mics_pkg::FN_SUB: begin
                        e_wr   = 1'b1;
                        e_wval = e_a - e_b;
                    end
                    mics_pkg::FN_SLT: begin
                        e_wr   = 1'b1;
                        e_wval = {31'd0, $signed(e_a) < $signed(e_b)};
                    end
                    mics_pkg::FN_SLL: begin
                        e_wr   = 1'b1;
                        e_wval = e_b << e_sh;
                    end
                    mics_pkg::FN_SRL: begin
                        e_wr   = 1'b1;
                        e_wval = e_b >> e_sh;
                    end
                    mics_pkg::FN_JR: begin
                        e_npc = e_a;
                    end
                    default: begin
                        e_status = mics_pkg::ST_SKIP;
                    end
                endcase
            end
            mics_pkg::OP_J: begin
                e_npc = {e_pc4[31:28], r_ins[25:0], 2'b00};
            end
            mics_pkg::OP_JAL: begin
                e_wr   = 1'b1;
                e_widx = mics_pkg::REG_RA;
                e_wval = e_pc4;
                e_npc  = {e_pc4[31:28], r_ins[25:0], 2'b00};
            end
            mics_pkg::OP_BEQ: begin
                if (e_a == e_b) begin
                    e_npc = e_pc4 + {e_simm[29:0], 2'b00};
                end
            end
            mics_pkg::OP_BNE: begin
                if (e_a != e_b) begin
                    e_npc = e_pc4 + {e_simm[29:0], 2'b00};
                end
            end
            mics_pkg::OP_ADDI: begin
                e_wr   = 1'b1;
                e_wval = e_a + e_simm;
            end
            mics_pkg::OP_SLTI: begin
                e_wr   = 1'b1;
                e_wval = {31'd0, $signed(e_a) < $signed(e_simm)};
            end
            mics_pkg::OP_ORI: begin
                e_wr   = 1'b1;
                e_wval = e_a | {16'd0, e_imm};
            end
            mics_pkg::OP_LUI: begin
                e_wr   = 1'b1;
                e_wval = {e_imm, 16'd0};
            end
            mics_pkg::OP_LW: begin
                e_mem  = 1'b1;
                e_load = 1'b1;
            end
            mics_pkg::OP_SW: begin
                e_mem = 1'b1;
            end
            mics_pkg::OP_COP1, mics_pkg::OP_LWC1, mics_pkg::OP_SWC1,
            mics_pkg::OP_IO_0, mics_pkg::OP_IO_1, mics_pkg::OP_IO_2,
            mics_pkg::OP_IO_3: begin
                e_status = mics_pkg::ST_SKIP;
            end
            default: begin
                // Invalid opcode: hold the PC, change nothing
                e_status = mics_pkg::ST_INVALID;
                e_npc    = r_pc;
            end
        endcase
    end

    // Drop writes to register zero
    assign e_wr_en = e_wr && (e_widx != 5'd0);

    // Program end lies at program_words * 4
    assign e_end  = {13'd0, r_pw, 2'b00};
    assign e_halt = (e_npc >= e_end);

    assign e_fire   = r_v1 && !e_mem && out_free;
    assign e_to_seq = r_v1 && e_mem && (r_mstate == mics_pkg::MS_IDLE);

    // ------------------------------------------------------------------
    // Memory sequencer: address reduction and data-memory access
    // ------------------------------------------------------------------
    logic [31:0]     red_q;
    logic [31:0]     red_qd;
    logic [31:0]     red_rem1;
    logic [31:0]     red_rem;
    logic [DA_W-1:0] red_addr;
    logic [31:0]     red_addr32;
    logic            ld_wr_en;

    // The reciprocal estimate of the quotient is low by at most one
    assign red_q      = r_prod[63:32];
    assign red_qd     = 32'(red_q * DW32);
    assign red_rem1   = r_m_sum - red_qd;
    assign red_rem    = (red_rem1 >= DW32) ? (red_rem1 - DW32) : red_rem1;
    assign red_addr   = red_rem[DA_W-1:0];
    assign red_addr32 = 32'(red_addr);

    always_comb begin
        n_mstate   = r_mstate;
        load_fire  = 1'b0;
        store_fire = 1'b0;
        case (r_mstate)
            mics_pkg::MS_IDLE: begin
                if (e_to_seq) begin
                    n_mstate = mics_pkg::MS_MUL;
                end
            end
            mics_pkg::MS_MUL: begin
                n_mstate = mics_pkg::MS_RED;
            end
            mics_pkg::MS_RED: begin
                if (r_m_load) begin
                    n_mstate = mics_pkg::MS_LOAD;
                end else if (out_free) begin
                    store_fire = 1'b1;
                    n_mstate   = mics_pkg::MS_IDLE;
                end
            end
            mics_pkg::MS_LOAD: begin
                if (out_free) begin
                    load_fire = 1'b1;
                    n_mstate  = mics_pkg::MS_IDLE;
                end
            end
            default: begin
                n_mstate = mics_pkg::MS_IDLE;
            end
        endcase
    end

    assign seq_fire = load_fire || store_fire;
    assign ld_wr_en = load_fire && (r_m_rt != 5'd0);

    // Read at the reduced address, then hold it while the load waits on the output
    assign dm_raddr = (r_mstate == mics_pkg::MS_RED) ? red_addr : r_m_addr;

    // The clearing sweep owns the write port until it completes
    assign dm_we    = r_clr || store_fire;
    assign dm_waddr = r_clr ? r_clr_addr : red_addr;
    assign dm_wdata = r_clr ? 32'd0 : r_m_b;

    // One register-file writer per cycle: execute or the finishing load
    assign rf_we   = (e_fire && e_wr_en) || ld_wr_en;
    assign rf_widx = ld_wr_en ? r_m_rt : e_widx;
    assign rf_wval = ld_wr_en ? dm_q : e_wval;

    // ------------------------------------------------------------------
    // Result selection
    // ------------------------------------------------------------------
    always_comb begin
        n_out = '0;
        if (e_fire) begin
            n_out.status      = e_status;
            n_out.next_pc     = e_npc;
            n_out.halted      = e_halt;
            n_out.reg_written = e_wr_en;
            n_out.reg_index   = e_wr_en ? e_widx : 5'd0;
            n_out.reg_value   = e_wr_en ? e_wval : 32'd0;
        end else begin
            n_out.status  = mics_pkg::ST_EXEC;
            n_out.next_pc = r_m_npc;
            n_out.halted  = r_m_halt;
            if (r_m_load) begin
                n_out.reg_written = ld_wr_en;
                n_out.reg_index   = ld_wr_en ? r_m_rt : 5'd0;
                n_out.reg_value   = ld_wr_en ? dm_q : 32'd0;
            end else begin
                n_out.mem_written = 1'b1;
                n_out.mem_index   = red_addr32[11:0];
                n_out.mem_value   = r_m_b;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= 32'd0;
            r_pw       <= '0;
            r_rvalid   <= 32'd0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_v1       <= 1'b0;
            r_mstate   <= mics_pkg::MS_IDLE;
            r_ov       <= 1'b0;
        end else begin
            r_mstate <= n_mstate;

            if (i_cfg.valid) begin
                r_pw <= i_cfg.program_words;
            end

            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == DA_W'(DATA_WORDS - 1)) begin
                    r_clr <= 1'b0;
                end
            end

            if (rf_we) begin
                r_rvalid[rf_widx] <= 1'b1;
            end

            if (e_fire || e_to_seq) begin
                r_pc <= e_npc;
            end

            if (in_acc) begin
                r_v1 <= 1'b1;
            end else if (e_fire || e_to_seq) begin
                r_v1 <= 1'b0;
            end

            if (e_fire || seq_fire) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ins     <= i_instr.instruction;
            r_byp_a   <= rf_we && (rf_widx == i_instr.instruction[25:21]);
            r_byp_b   <= rf_we && (rf_widx == i_instr.instruction[20:16]);
            r_byp_val <= rf_wval;
        end
        if (e_to_seq) begin
            r_m_load <= e_load;
            r_m_sum  <= e_a + e_simm;
            r_m_b    <= e_b;
            r_m_rt   <= e_rt;
            r_m_npc  <= e_npc;
            r_m_halt <= e_halt;
        end
        if (r_mstate == mics_pkg::MS_MUL) begin
            r_prod <= 64'(r_m_sum) * 64'(RECIP);
        end
        if (r_mstate == mics_pkg::MS_RED) begin
            r_m_addr <= red_addr;
        end
        if (e_fire || seq_fire) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid       = r_ov;
    assign o_result.status      = r_out.status;
    assign o_result.next_pc     = r_out.next_pc;
    assign o_result.halted      = r_out.halted;
    assign o_result.reg_written = r_out.reg_written;
    assign o_result.reg_index   = r_out.reg_index;
    assign o_result.reg_value   = r_out.reg_value;
    assign o_result.mem_written = r_out.mem_written;
    assign o_result.mem_index   = r_out.mem_index;
    assign o_result.mem_value   = r_out.mem_value;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Execute and the memory sequencer never hold work at the same time
    a_single_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_v1 && r_mstate != mics_pkg::MS_IDLE))
        else $error("execute and memory sequencer both occupied");

    // Execute and a finishing load never write the register file together
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(e_fire && e_wr_en && ld_wr_en))
        else $error("two register-file writers in one cycle");

    // Register zero is never reported as written
    a_reg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.reg_written) |-> (o_result.reg_index != 5'd0))
        else $error("write to register zero reported");

    // A store never lands while the clearing sweep still runs
    a_store_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_fire |-> !r_clr)
        else $error("store during data-memory clear");

    // A memory instruction leaving execute starts the address multiply next
    a_seq_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_to_seq |=> (r_mstate == mics_pkg::MS_MUL))
        else $error("memory sequencer did not start");

endmodule
